FILE: design/sfr_pkg.sv
// shared types and constants of the stuffed frame receiver
package sfr_pkg;

  localparam logic [7:0] MARK_BYTE  = 8'hAA;
  localparam logic [7:0] START_BYTE = 8'hCC;
  localparam logic [7:0] END_BYTE   = 8'hEE;

  localparam logic [1:0] REG_SLAVE_ID     = 2'd0;
  localparam logic [1:0] REG_COMMAND_CODE = 2'd1;
  localparam logic [1:0] REG_WAIT_TICKS   = 2'd2;

  localparam logic [15:0] WAIT_TICKS_RESET = 16'd100;

  typedef enum logic [1:0] {
    LV_HUNT,
    LV_HEADER,
    LV_DATA,
    LV_ESCAPE
  } level_t;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_BYTE,
    EV_ACCEPT,
    EV_DROP,
    EV_SHORT,
    EV_OVERFLOW,
    EV_TIMEOUT,
    EV_RESTART
  } event_t;

  typedef enum logic [1:0] {
    BC_MARK,
    BC_START,
    BC_END,
    BC_OTHER
  } byte_class_t;

  typedef struct packed {
    logic        is_tick;
    byte_class_t cls;
    logic [7:0]  data;
  } cmd_t;

  typedef struct packed {
    event_t     ev;
    logic [7:0] data;
    logic [5:0] idx;
    logic [6:0] len;
    logic [7:0] rc;
  } res_t;

endpackage

FILE: design/sfr_front.sv
// front end: accepts words, classifies them and queues them for the engine
module sfr_front import sfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       req_type,
  input  logic [7:0] rx_byte,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_take
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       put;
  logic       take;
  cmd_t       incoming;

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign put       = push && !full;
  assign take      = cmd_take && cmd_valid;

  always_comb begin
    incoming.is_tick = req_type;
    incoming.data    = rx_byte;
    case (rx_byte)
      MARK_BYTE:  incoming.cls = BC_MARK;
      START_BYTE: incoming.cls = BC_START;
      END_BYTE:   incoming.cls = BC_END;
      default:    incoming.cls = BC_OTHER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (put) begin
      q[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (put) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({put, take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("command queue count out of range");
  a_put_grows: assert property (@(posedge clk) disable iff (rst)
    (put && !take) |=> count == $past(count) + 2'd1)
    else $error("command queue did not grow on a lone put");

endmodule

FILE: design/sfr_back.sv
// back end: frame state machine, config registers and result queue
module sfr_back import sfr_pkg::*; #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_take,
  output logic        empty,
  input  logic        pop,
  output res_t        res
);

  localparam int CW = $clog2(BUFFER_BYTES + 1);

  logic [7:0]    slave_id;
  logic [7:0]    command_code;
  logic [15:0]   wait_ticks;

  level_t        level, level_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [7:0]    first_byte, first_byte_next;
  logic [7:0]    second_byte, second_byte_next;
  logic [7:0]    third_byte, third_byte_next;
  logic [15:0]   ticks_left, ticks_left_next;
  logic [CW+6:0] cnt_wide;
  res_t          res_next;
  logic          store;
  logic          match;

  res_t          rq [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    res_count;
  logic          go;
  logic          drain;

  assign drain    = pop && !empty;
  assign empty    = (res_count == 2'd0);
  assign res      = rq[rd_ptr];
  assign go       = cmd_valid && ((res_count != 2'd2) || drain);
  assign cmd_take = go;
  assign cnt_wide = {7'd0, byte_count};
  assign match    = (byte_count >= CW'(2)) && (first_byte == slave_id)
                    && (second_byte == command_code);

  always_comb begin
    level_next       = level;
    byte_count_next  = byte_count;
    first_byte_next  = first_byte;
    second_byte_next = second_byte;
    third_byte_next  = third_byte;
    ticks_left_next  = ticks_left;
    res_next         = '0;
    res_next.ev      = EV_NONE;
    store            = 1'b0;
    if (cmd.is_tick) begin
      if (ticks_left == 16'd0) begin
        level_next      = LV_HUNT;
        byte_count_next = '0;
        ticks_left_next = wait_ticks;
        res_next.ev     = EV_TIMEOUT;
      end else begin
        ticks_left_next = ticks_left - 16'd1;
      end
    end else begin
      ticks_left_next = wait_ticks;
      if (byte_count >= CW'(BUFFER_BYTES)) begin
        level_next      = LV_HUNT;
        byte_count_next = '0;
        res_next.ev     = EV_OVERFLOW;
      end else begin
        case (level)
          LV_HUNT: begin
            if (cmd.cls == BC_MARK) level_next = LV_HEADER;
          end
          LV_HEADER: begin
            if (cmd.cls == BC_START) begin
              level_next      = LV_DATA;
              byte_count_next = '0;
            end else begin
              level_next = LV_HUNT;
            end
          end
          LV_DATA: begin
            if (cmd.cls == BC_MARK) level_next = LV_ESCAPE;
            else store = 1'b1;
          end
          LV_ESCAPE: begin
            case (cmd.cls)
              BC_MARK: begin
                level_next = LV_DATA;
                store      = 1'b1;
              end
              BC_START: begin
                level_next      = LV_DATA;
                byte_count_next = '0;
                res_next.ev     = EV_RESTART;
              end
              BC_END: begin
                level_next   = LV_HUNT;
                res_next.len = cnt_wide[6:0];
                // a dropped frame keeps its count until the next header or a timeout
                if (!match) begin
                  res_next.ev = EV_DROP;
                end else if (byte_count < CW'(5)) begin
                  byte_count_next = '0;
                  res_next.ev     = EV_SHORT;
                end else begin
                  byte_count_next = '0;
                  res_next.ev     = EV_ACCEPT;
                  res_next.rc     = third_byte;
                end
              end
              default: ;  // other byte after escape is ignored
            endcase
          end
          default: level_next = LV_HUNT;
        endcase
        if (store) begin
          if (byte_count == CW'(0)) first_byte_next = cmd.data;
          if (byte_count == CW'(1)) second_byte_next = cmd.data;
          if (byte_count == CW'(2)) third_byte_next = cmd.data;
          byte_count_next = byte_count + CW'(1);
          res_next.ev     = EV_BYTE;
          res_next.data   = cmd.data;
          res_next.idx    = cnt_wide[5:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level       <= LV_HUNT;
      byte_count  <= '0;
      first_byte  <= 8'd0;
      second_byte <= 8'd0;
      third_byte  <= 8'd0;
      ticks_left  <= WAIT_TICKS_RESET;
    end else if (go) begin
      level       <= level_next;
      byte_count  <= byte_count_next;
      first_byte  <= first_byte_next;
      second_byte <= second_byte_next;
      third_byte  <= third_byte_next;
      ticks_left  <= ticks_left_next;
    end else if (cfg_we && cfg_index == REG_WAIT_TICKS) begin
      ticks_left <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_id     <= 8'd0;
      command_code <= 8'd0;
      wait_ticks   <= WAIT_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SLAVE_ID:     slave_id     <= cfg_data[7:0];
        REG_COMMAND_CODE: command_code <= cfg_data[7:0];
        REG_WAIT_TICKS:   wait_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  // result queue, two words deep
  always_ff @(posedge clk) begin
    if (go) begin
      rq[wr_ptr] <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= 1'b0;
      rd_ptr    <= 1'b0;
      res_count <= 2'd0;
    end else begin
      if (go) begin
        wr_ptr <= ~wr_ptr;
      end
      if (drain) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({go, drain})
        2'b10:   res_count <= res_count + 2'd1;
        2'b01:   res_count <= res_count - 2'd1;
        default: res_count <= res_count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CW'(BUFFER_BYTES))
    else $error("byte count beyond buffer size");
  a_res_bound: assert property (@(posedge clk) disable iff (rst) res_count != 2'd3)
    else $error("result queue count out of range");
  a_reload: assert property (@(posedge clk) disable iff (rst)
    (go && !cmd.is_tick) |=> ticks_left == $past(wait_ticks))
    else $error("tick counter not reloaded on a byte");

endmodule

FILE: design/stuffed_frame_receiver_top.sv
// a pushed word is held in the command queue, then its result in the result queue
// throughput: one word per cycle while results are popped, set by the
// frame engine and the two-deep command and result queues
// every word gives exactly one result word, event none included
// rst (synchronous) resets both queues, frame state and config registers
module stuffed_frame_receiver_top import sfr_pkg::*; #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic        req_type,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  event_res,
  output logic [7:0]  data_byte,
  output logic [5:0]  byte_index,
  output logic [6:0]  frame_length,
  output logic [7:0]  return_code
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;
  res_t res;

  sfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req_type  (req_type),
    .rx_byte   (rx_byte),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  sfr_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign event_res    = res.ev;
  assign data_byte    = res.data;
  assign byte_index   = res.idx;
  assign frame_length = res.len;
  assign return_code  = res.rc;

endmodule
